@@ hw/rtl/tdpt_pkg.sv @@
// Shared types for the trial-division primality tester.
`timescale 1ns / 1ps

package tdpt_pkg;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // Status handed from the divider to the sequencer
    typedef struct packed {
        logic done;      // quotient and remainder final this cycle
        logic rem_zero;  // divisor divides exactly
    } div_stat_t;

endpackage

@@ hw/rtl/tdpt_if.sv @@
// Valid/ready channel interfaces for candidate and result items.
`timescale 1ns / 1ps

interface tdpt_cand_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

@@ hw/rtl/tdpt_div.sv @@
// Restoring radix-2 divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module tdpt_div #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   dividend,
    input  logic [WIDTH-1:0]   divisor,
    output logic [WIDTH-1:0]   quotient,
    output tdpt_pkg::div_stat_t stat
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH+1:0] diff;

    // partial remainder with the next dividend bit shifted in
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(WIDTH);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
            if (!diff[WIDTH+1])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient      = quo_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

@@ hw/rtl/trial_division_primality_test.sv @@
// Top level: sequencer for trial division around the shared divider.
`timescale 1ns / 1ps

// Tests one unsigned candidate per item and returns one is_prime flag.
// 0, 1 and even values, 2 among them, are answered without division. An odd
// candidate of 3 or more is divided by 3, 5, 7, ... on a single radix-2
// divider; the division gives both the remainder and the quotient used for
// the bound d <= n/d. At most about 2^(WIDTH/2-1) divisors are tried for a
// large prime. The input is not ready while an item is under test or while
// its result waits to enter the output register; a finished result sits in
// the output register, so the next item can be taken while it waits.

module trial_division_primality_test #(
    parameter int WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    tdpt_cand_if.sink    cand,
    tdpt_res_if.source   res
);

    tdpt_pkg::state_t state_reg, state_next;

    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic             prime_reg, prime_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_prime_reg, out_prime_next;

    logic                div_start;
    logic [WIDTH-1:0]    div_dividend;
    logic [WIDTH-1:0]    quotient;
    tdpt_pkg::div_stat_t div_stat;

    logic accept;
    logic out_free;

    assign cand.ready = (state_reg == tdpt_pkg::S_IDLE);
    assign accept     = cand.valid && cand.ready;
    assign out_free   = !out_valid_reg || res.ready;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_prime_next = out_prime_reg;
        div_start      = 1'b0;
        div_dividend   = n_reg;

        unique case (state_reg)
            tdpt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    n_next = cand.candidate;
                    d_next = WIDTH'(3);
                    priority if (cand.candidate <= WIDTH'(1))
                    begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::S_DONE;
                    end
                    else if (cand.candidate == WIDTH'(2))
                    begin
                        prime_next = 1'b1;
                        state_next = tdpt_pkg::S_DONE;
                    end
                    else if (!cand.candidate[0])
                    begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::S_DONE;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = cand.candidate;
                        state_next   = tdpt_pkg::S_DIV;
                    end
                end
            end
            tdpt_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    // bound first: d > n/d means no divisor is left
                    priority if (d_reg > quotient)
                    begin
                        prime_next = 1'b1;
                        state_next = tdpt_pkg::S_DONE;
                    end
                    else if (div_stat.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::S_DONE;
                    end
                    else
                    begin
                        d_next    = d_reg + WIDTH'(2);
                        div_start = 1'b1;
                    end
                end
            end
            tdpt_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                    state_next     = tdpt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdpt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        prime_reg     <= prime_next;
        out_prime_reg <= out_prime_next;
    end

    tdpt_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (d_next),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign res.valid    = out_valid_reg;
    assign res.is_prime = out_prime_reg;

endmodule

@@ dv/trial_division_primality_test_test.sv @@
// Self-checking testbench for the trial-division primality tester.
`timescale 1ns / 1ps

module trial_division_primality_test_test;

    localparam int WIDTH        = 32;
    localparam int DRAIN_CYCLES = 64;
    // Slowest legal stimulus is every random item an odd square near 2^22;
    // the limit sits well above what that stimulus needs.
    localparam int LIMIT_CYCLES = 12_000_000;

    typedef struct {
        logic [WIDTH-1:0] candidate;
        logic             is_prime;
    } prime_verdict_t;

    logic clk;
    logic rst_n;

    tdpt_cand_if #(.WIDTH(WIDTH)) cand_if ();
    tdpt_res_if                   res_if ();

    trial_division_primality_test #(
        .WIDTH (WIDTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand_if.sink),
        .res   (res_if.source)
    );

    logic [WIDTH-1:0] cand_queue[$];
    prime_verdict_t   verdict_q[$];
    prime_verdict_t   oldest_verdict;
    int               fail_count;
    int               burst_left;
    int               gap_left;
    logic [15:0]      stall_pattern;
    int               reload_count;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic is_prime_by_division(input logic [WIDTH-1:0] n);
        logic [WIDTH-1:0] d;
        if (n <= WIDTH'(1))
            return 1'b0;
        if (n == WIDTH'(2))
            return 1'b1;
        if (!n[0])
            return 1'b0;
        d = WIDTH'(3);
        // d <= n/d is the exact form of d*d <= n
        while (d <= n / d)
        begin
            if (n % d == WIDTH'(0))
                return 1'b0;
            d = d + WIDTH'(2);
        end
        return 1'b1;
    endfunction

    // Most random candidates stay cheap: small values, values up to 2^20, odd
    // squares, large values with a known small odd factor, and large even values.
    function automatic logic [WIDTH-1:0] random_candidate();
        int unsigned sel;
        int unsigned f;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return $urandom_range(0, 4095);
        else if (sel < 55)
            return $urandom_range(0, 20'hFFFFF);
        else if (sel < 75)
        begin
            f = 2 * $urandom_range(1, 127) + 1;
            return f * $urandom_range(0, 32'hFFFF_FFFF / f);
        end
        else if (sel < 87)
        begin
            f = 2 * $urandom_range(1, 1023) + 1;
            return f * f;
        end
        else
            return $urandom() & 32'hFFFF_FFFE;
    endfunction

    // Driver: bursts of items with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_if.valid     <= 1'b0;
            cand_if.candidate <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (cand_if.valid && cand_if.ready)
                verdict_q.insert(verdict_q.size(),
                                 prime_verdict_t'{cand_if.candidate,
                                     is_prime_by_division(cand_if.candidate)});
            if (!cand_if.valid || cand_if.ready)
            begin
                if (gap_left > 0 || cand_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    cand_if.valid <= 1'b0;
                end
                else
                begin
                    cand_if.valid     <= 1'b1;
                    cand_if.candidate <= cand_queue.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(20, 40);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver stalls follow a rotating 16-bit pattern, reloaded after each full rotation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_pattern = 16'hFFFF;
            reload_count  = 0;
        end
        else
        begin
            res_if.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            if (reload_count == 15)
            begin
                reload_count  = 0;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : 16'($urandom());
            end
            else
                reload_count++;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("is_prime: result with no item outstanding, actual %0b",
                       res_if.is_prime);
                fail_count++;
            end
            else
            begin
                oldest_verdict = verdict_q.pop_front();
                if (res_if.is_prime !== oldest_verdict.is_prime)
                begin
                    $error("is_prime (candidate %0d): expected %0b, actual %0b",
                           oldest_verdict.candidate, oldest_verdict.is_prime,
                           res_if.is_prime);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cand_if.valid     = 1'b0;
        cand_if.candidate = '0;
        res_if.ready      = 1'b0;
        fail_count        = 0;

        // Directed: trivial answers, small primes and squares at the bound,
        // mid-size primes, and both ends of the field.
        cand_queue = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15,
                       32'd25, 32'd49, 32'd97, 32'd121, 32'd169, 32'd65521,
                       32'd65535, 32'd1018081, 32'd1022117, 32'd1048573,
                       32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE,
                       32'hFFFF_FFFF};
        repeat (78)
            cand_queue.insert(cand_queue.size(), random_candidate());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cand_queue.size() != 0 || cand_if.valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
